[design/sha256_message_digest_top_defines.svh]
// ----------------------------------------------------------------------------
// SHA-256 message digest: assertion macros
// Shared assertion shorthands, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_TOP_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_TOP_DEFINES_SVH

// Same-cycle implication
`define SMD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SMD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/sha256md_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 message digest package
// Word type, round constants, initial hash values and round functions.
// ----------------------------------------------------------------------------
package sha256md_pkg;

   typedef logic [31:0] word_type;

   localparam logic [7:0] PadMark   = 8'h80;
   localparam logic [5:0] LenStart  = 6'd56;
   localparam logic [5:0] LastSlot  = 6'd63;
   localparam logic [5:0] LastRound = 6'd63;
   localparam logic [2:0] LastWord  = 3'd7;

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Rotate right by a constant amount
   function automatic word_type rotr(word_type x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type choose(word_type e, word_type f, word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic word_type major(word_type a, word_type b, word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

[design/sha256_message_digest_top.sv]
// ----------------------------------------------------------------------------
// SHA-256 message digest top level
// Hashes a byte stream, one byte per item, and returns the eight digest words.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_stall   data_byte, has_byte, end_of_message
//   rsp      out  rsp_valid / rsp_stall   digest_word, word_index, last_word
//
// A byte that does not complete a block is shifted into the block window; the
// 64th byte of a block starts the rounds on the single round unit, then the
// hash update. Closing a message feeds padding one byte a cycle, pausing for
// the rounds when a block fills, until the last block is full (a second block
// when the length does not fit), then the 8 words.
// Synchronous reset restores the initial hash; req_stall stays high while busy.
// rsp_stall holds the current digest word until it is taken.
// ----------------------------------------------------------------------------
`include "sha256_message_digest_top_defines.svh"

module sha256_message_digest_top
   import sha256md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_MARK   = 7'b0000010,
      S_ZERO   = 7'b0000100,
      S_LEN    = 7'b0001000,
      S_ROUND  = 7'b0010000,
      S_UPDATE = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type    state_ff, state_in;
   state_type    resume_ff, resume_in;
   logic [5:0]   round_ff, round_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  len_ff, len_in;
   logic [511:0] msg_ff, msg_in;
   logic [2:0]   idx_ff, idx_in;
   word_type     hash_ff [8];
   word_type     hash_in [8];
   word_type     v_ff [8];
   word_type     v_in [8];

   logic         feed_en;
   logic [7:0]   feed_byte;
   state_type    after_feed;
   logic [63:0]  len_shift;
   word_type     w0, w1, w9, w14;
   word_type     new_word;
   word_type     t1, t2;

   // Length byte for the current slot, most significant byte at slot 56
   assign len_shift = len_ff >> {~fill_ff[2:0], 3'b000};

   // Message window taps and schedule extension
   assign w0       = msg_ff[511:480];
   assign w1       = msg_ff[479:448];
   assign w9       = msg_ff[223:192];
   assign w14      = msg_ff[63:32];
   assign new_word = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

   // Shared round unit
   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + choose(v_ff[4], v_ff[5], v_ff[6])
             + RoundK[round_ff] + w0;
   assign t2 = big_sigma0(v_ff[0]) + major(v_ff[0], v_ff[1], v_ff[2]);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      resume_in  = resume_ff;
      round_in   = round_ff;
      fill_in    = fill_ff;
      len_in     = len_ff;
      msg_in     = msg_ff;
      idx_in     = idx_ff;
      hash_in    = hash_ff;
      v_in       = v_ff;
      feed_en    = 1'b0;
      feed_byte  = '0;
      after_feed = S_IDLE;

      unique case (state_ff)
         S_IDLE: begin
            after_feed = req_end_of_message ? S_MARK : S_IDLE;
            if (req_valid) begin
               if (req_has_byte) begin
                  feed_en   = 1'b1;
                  feed_byte = req_data_byte;
                  len_in    = len_ff + 64'd8;
               end else begin
                  state_in = after_feed;
               end
            end
         end
         S_MARK: begin
            feed_en    = 1'b1;
            feed_byte  = PadMark;
            after_feed = (fill_ff == LenStart - 6'd1) ? S_LEN : S_ZERO;
         end
         S_ZERO: begin
            feed_en    = 1'b1;
            after_feed = (fill_ff == LenStart - 6'd1) ? S_LEN : S_ZERO;
         end
         S_LEN: begin
            feed_en    = 1'b1;
            feed_byte  = len_shift[7:0];
            after_feed = (fill_ff == LastSlot) ? S_OUT : S_LEN;
         end
         S_ROUND: begin
            msg_in   = {msg_ff[479:0], new_word};
            v_in[7]  = v_ff[6];
            v_in[6]  = v_ff[5];
            v_in[5]  = v_ff[4];
            v_in[4]  = v_ff[3] + t1;
            v_in[3]  = v_ff[2];
            v_in[2]  = v_ff[1];
            v_in[1]  = v_ff[0];
            v_in[0]  = t1 + t2;
            round_in = round_ff + 6'd1;
            if (round_ff == LastRound) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + v_ff[i];
            end
            state_in = resume_ff;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LastWord) begin
                  state_in = S_IDLE;
                  hash_in  = InitHash;
                  len_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Byte feed into the block window; a full block starts compression
      if (feed_en) begin
         msg_in  = {msg_ff[503:0], feed_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff == LastSlot) begin
            state_in  = S_ROUND;
            resume_in = after_feed;
            v_in      = hash_ff;
            round_in  = '0;
         end else begin
            state_in = after_feed;
         end
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         resume_ff <= S_IDLE;
         round_ff  <= '0;
         fill_ff   <= '0;
         len_ff    <= '0;
         idx_ff    <= '0;
         hash_ff   <= InitHash;
      end else begin
         state_ff  <= state_in;
         resume_ff <= resume_in;
         round_ff  <= round_in;
         fill_ff   <= fill_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         hash_ff   <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      v_ff   <= v_in;
   end

   // Ports
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_OUT);
   assign rsp_digest_word = hash_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == LastWord);

   // Checks
   `SMD_ASSERT_NEXT(a_round_to_update, (state_ff == S_ROUND) && (round_ff == LastRound),
      state_ff == S_UPDATE, "last round not followed by hash update")
   `SMD_ASSERT_NOW(a_round_block_full, state_ff == S_ROUND,
      fill_ff == 6'd0, "compression running on a partial block")
   `SMD_ASSERT_NOW(a_len_slots, state_ff == S_LEN,
      fill_ff[5:3] == 3'b111, "length byte outside the last eight slots")
   `SMD_ASSERT_NOW(a_rsp_blocks_req, rsp_valid,
      req_stall, "input taken while digest words are pending")
   `SMD_ASSERT_NEXT(a_digest_done, rsp_valid && !rsp_stall && rsp_last_word,
      (state_ff == S_IDLE) && (len_ff == 64'd0) && (fill_ff == 6'd0),
      "state not restored after the last digest word")

endmodule
